>>> rtl/fud_pkg.sv
// Shared types and character constants for the form body decoder.
package fud_pkg;

    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_PAIR  = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_PCT  = 2'd1;
    localparam logic [1:0] PH_HELD = 2'd2;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int MAX_RESULTS = 4;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_end;
    } body_beat_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       run_last;
    } result_beat_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic       in_value;
        logic [1:0] percent_phase;
        logic [7:0] held_char;
        logic       key_nonempty;
    } state_t;

    typedef struct packed {
        item_t [MAX_RESULTS-1:0] items;
        logic [2:0]              count;
    } step_t;

endpackage

>>> rtl/fud_decode.sv
// Per-byte decode step: next state and the results one body byte causes.
module fud_decode (
    input  fud_pkg::body_beat_t beat,
    input  fud_pkg::state_t     state,
    output fud_pkg::state_t     state_next,
    output fud_pkg::step_t      step
);

    typedef struct packed {
        logic          valid;
        fud_pkg::item_t item;
    } slot_t;

    function automatic logic hex_ok(input logic [7:0] c);
        hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
              || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h30 && c <= 8'h39)
            v = c - 8'h30;
        else if (c >= 8'h61 && c <= 8'h66)
            v = c - 8'h57;
        else if (c >= 8'h41 && c <= 8'h46)
            v = c - 8'h37;
        else
            v = 8'h00;
        hex_val = v[3:0];
    endfunction

    function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] v;
        logic       lead;
        lead = (a == fud_pkg::CH_SPACE) || (a >= 8'h09 && a <= 8'h0D)
            || (a == fud_pkg::CH_PLUS) || (a == fud_pkg::CH_MINUS);
        v = 8'h00;
        if (lead)
        begin
            if (hex_ok(b))
                v = {4'h0, hex_val(b)};
            if (a == fud_pkg::CH_MINUS)
                v = 8'h00 - v;
        end
        else if (hex_ok(a))
        begin
            v = hex_ok(b) ? {hex_val(a), hex_val(b)} : {4'h0, hex_val(a)};
        end
        decode_pair = v;
    endfunction

    function automatic slot_t put_char(input logic iv, input logic kn, input logic [7:0] c);
        slot_t s;
        s.valid     = iv ? kn : 1'b1;
        s.item.kind = iv ? fud_pkg::KIND_VALUE : fud_pkg::KIND_KEY;
        s.item.data = c;
        put_char = s;
    endfunction

    slot_t [fud_pkg::MAX_RESULTS-1:0] slots;

    always_comb
    begin
        logic [7:0] c;
        logic       last;
        logic       iv;
        logic       kn;
        logic [2:0] n;
        fud_pkg::state_t nx;

        c    = beat.body_byte;
        last = beat.body_end;
        nx   = state;
        iv   = state.in_value;
        kn   = state.key_nonempty;
        for (int i = 0; i < fud_pkg::MAX_RESULTS; i++)
            slots[i] = '0;

        if (state.percent_phase == fud_pkg::PH_PCT && last)
        begin
            slots[0] = put_char(iv, kn, fud_pkg::CH_PCT);
            kn = iv ? kn : 1'b1;
        end

        if (state.percent_phase == fud_pkg::PH_HELD)
        begin
            slots[1] = put_char(iv, kn, decode_pair(state.held_char, c));
            kn = iv ? kn : 1'b1;
            nx.percent_phase = fud_pkg::PH_NONE;
            nx.held_char     = 8'h00;
        end
        else if (state.percent_phase == fud_pkg::PH_PCT && !last)
        begin
            nx.held_char     = c;
            nx.percent_phase = fud_pkg::PH_HELD;
        end
        else
        begin
            nx.percent_phase = fud_pkg::PH_NONE;
            if (c == fud_pkg::CH_AMP)
            begin
                slots[1].valid     = kn;
                slots[1].item.kind = fud_pkg::KIND_PAIR;
                slots[1].item.data = 8'h00;
                iv = 1'b0;
                kn = 1'b0;
            end
            else if (c == fud_pkg::CH_EQ && !iv)
            begin
                iv = 1'b1;
            end
            else if (c == fud_pkg::CH_PLUS)
            begin
                slots[1] = put_char(iv, kn, fud_pkg::CH_SPACE);
                kn = iv ? kn : 1'b1;
            end
            else if (c == fud_pkg::CH_PCT && !last)
            begin
                nx.percent_phase = fud_pkg::PH_PCT;
            end
            else
            begin
                slots[1] = put_char(iv, kn, c);
                kn = iv ? kn : 1'b1;
            end
        end

        nx.in_value     = iv;
        nx.key_nonempty = kn;

        if (last)
        begin
            slots[2].valid     = kn;
            slots[2].item.kind = fud_pkg::KIND_PAIR;
            slots[2].item.data = 8'h00;
            slots[3].valid     = 1'b1;
            slots[3].item.kind = fud_pkg::KIND_END;
            slots[3].item.data = 8'h00;
            nx = '0;
        end

        step = '0;
        n    = 3'd0;
        for (int i = 0; i < fud_pkg::MAX_RESULTS; i++)
        begin
            if (slots[i].valid)
            begin
                step.items[n[1:0]] = slots[i].item;
                n = n + 3'd1;
            end
        end
        step.count = n;
        state_next = nx;
    end

endmodule

>>> rtl/fud_result_queue.sv
// Result register bank: holds the results of one byte and hands them out a beat at a time.
module fud_result_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  fud_pkg::step_t        step,
    output logic                  busy,
    output logic                  done,
    output logic                  result_valid,
    input  logic                  result_stall,
    output fud_pkg::result_beat_t result
);

    fud_pkg::item_t [fud_pkg::MAX_RESULTS-1:0] items_reg;
    fud_pkg::item_t [fud_pkg::MAX_RESULTS-1:0] items_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [1:0] idx_reg, idx_next;
    logic       is_last;

    assign busy         = cnt_reg != 3'd0;
    assign is_last      = {1'b0, idx_reg} == (cnt_reg - 3'd1);
    assign done         = busy && !result_stall && is_last;
    assign result_valid = busy;

    always_comb
    begin
        result.kind     = items_reg[idx_reg].kind;
        result.data     = items_reg[idx_reg].data;
        result.run_last = is_last;
    end

    always_comb
    begin
        items_next = items_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            items_next = step.items;
            cnt_next   = step.count;
            idx_next   = 2'd0;
        end
        else if (done)
        begin
            cnt_next = 3'd0;
            idx_next = 2'd0;
        end
        else if (busy && !result_stall)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        items_reg <= items_next;
    end

endmodule

>>> rtl/form_urlencoded_decoder.sv
// Top level of the streaming form body decoder.
//
//  channel  direction  handshake                  payload
//  body     in         body_valid / body_stall    body_byte, body_end
//  result   out        result_valid / result_stall kind, data, run_last
//
// A body byte is decoded in the cycle it is taken; its results sit in the
// result registers from the next cycle, one beat per unstalled cycle.
// A byte with at most one result sustains one byte per unstalled cycle; a
// byte with n results is held until the single result port sends them all.
// Reset clears the decode state and empties the result registers.
// body_stall rises while results of the previous byte other than the one
// being taken this cycle are still waiting.
module form_urlencoded_decoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  body_valid,
    output logic                  body_stall,
    input  fud_pkg::body_beat_t   body,
    output logic                  result_valid,
    input  logic                  result_stall,
    output fud_pkg::result_beat_t result
);

    fud_pkg::state_t state_reg, state_next, dec_state;
    fud_pkg::step_t  step;
    logic            busy, done, accept, load;

    assign body_stall = busy && !done;
    assign accept     = body_valid && !body_stall;
    assign load       = accept && (step.count != 3'd0);

    fud_decode u_decode (
        .beat       (body),
        .state      (state_reg),
        .state_next (dec_state),
        .step       (step)
    );

    fud_result_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .step         (step),
        .busy         (busy),
        .done         (done),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign state_next = accept ? dec_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else
            state_reg <= state_next;
    end

endmodule
